// File: rtl/core/obis_pkg.sv
package obis_pkg;

    localparam int unsigned MAX_VALUE_LEN = 32;
    localparam int unsigned NUM_CODES     = 27;
    localparam int unsigned CODE_SLOT     = 11;
    localparam int unsigned CODE_W        = 5;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned LEN_W         = $clog2(MAX_VALUE_LEN + 1);
    localparam int unsigned ADDR_W        = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;

    localparam logic [POS_W-1:0]     POS_MAX   = '1;
    localparam logic [NUM_CODES-1:0] ALL_CODES = '1;
    localparam logic [CODE_W-1:0]    TIME_CODE = '0;

    localparam logic [7:0] TERM_TIME  = "W";
    localparam logic [7:0] TERM_VALUE = "*";

    // prefixes are right-aligned in each slot, first character highest
    localparam logic [CODE_SLOT*8-1:0] CODE_STR [NUM_CODES] = '{
        "0-0:1.0.0(",  "1-0:1.8.0(",  "1-0:2.8.0(",  "1-0:3.8.0(",
        "1-0:4.8.0(",  "1-0:1.7.0(",  "1-0:2.7.0(",  "1-0:3.7.0(",
        "1-0:4.7.0(",  "1-0:21.7.0(", "1-0:41.7.0(", "1-0:61.7.0(",
        "1-0:22.7.0(", "1-0:42.7.0(", "1-0:62.7.0(", "1-0:23.7.0(",
        "1-0:43.7.0(", "1-0:63.7.0(", "1-0:24.7.0(", "1-0:44.7.0(",
        "1-0:64.7.0(", "1-0:32.7.0(", "1-0:52.7.0(", "1-0:72.7.0(",
        "1-0:31.7.0(", "1-0:51.7.0(", "1-0:71.7.0("
    };

    localparam int unsigned CODE_LEN [NUM_CODES] = '{
        10, 10, 10, 10, 10, 10, 10, 10, 10,
        11, 11, 11, 11, 11, 11, 11, 11, 11,
        11, 11, 11, 11, 11, 11, 11, 11, 11
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } drain_state_t;

    typedef struct packed {
        logic [NUM_CODES-1:0] mask;
        logic                 hit;
        logic [CODE_W-1:0]    idx;
    } match_res_t;

    function automatic logic [7:0] code_char(input int unsigned i, input logic [POS_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (32'(pos) < CODE_LEN[i]) begin
            c = CODE_STR[i][(CODE_LEN[i] - 1 - 32'(pos)) * 8 +: 8];
        end
        return c;
    endfunction

endpackage

// File: rtl/core/obis_match.sv
module obis_match import obis_pkg::*; (
    input  logic [NUM_CODES-1:0] mask,
    input  logic [POS_W-1:0]     pos,
    input  logic [7:0]           ch,
    output match_res_t           res
);

    logic [NUM_CODES-1:0] keep;

    always_comb begin
        for (int i = 0; i < NUM_CODES; i++) begin
            keep[i] = mask[i] && (32'(pos) < CODE_LEN[i]) && (code_char(i, pos) == ch);
        end
    end

    // lowest surviving index whose prefix ends at this position
    always_comb begin
        res.mask = keep;
        res.hit  = 1'b0;
        res.idx  = '0;
        for (int i = NUM_CODES - 1; i >= 0; i--) begin
            if (keep[i] && (CODE_LEN[i] == 32'(pos) + 1)) begin
                res.hit = 1'b1;
                res.idx = CODE_W'(i);
            end
        end
    end

endmodule

// File: rtl/core/obis_line_value_extractor_top.sv
// an empty-value result is shown in the cycle after the character that causes it
// value run (after the terminator): each buffered character in turn is read, then
// loaded into the output register when free; input is held off for the whole run
// otherwise one character per cycle while the output register is free
// reset: synchronous active-low aresetn clears line and drain state, buffer is not cleared
module obis_line_value_extractor_top import obis_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_ch,
    input  logic              s_line_start,
    input  logic              s_line_end,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CODE_W-1:0] m_code_index,
    output logic [7:0]        m_value_char,
    output logic              m_value_empty,
    output logic              m_truncated,
    output logic              m_last_of_value
);

    logic [NUM_CODES-1:0] mask_reg, mask_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 matched_reg, matched_next;
    logic [CODE_W-1:0]    idx_reg, idx_next;
    logic                 done_reg, done_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 ovf_reg, ovf_next;

    drain_state_t         st_reg, st_next;
    logic [LEN_W-1:0]     dr_idx_reg, dr_idx_next;
    logic [LEN_W-1:0]     dr_len_reg;
    logic [CODE_W-1:0]    dr_code_reg;
    logic                 dr_ovf_reg;

    logic [7:0]           value_mem [MAX_VALUE_LEN];
    logic [7:0]           rd_data_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]    code_reg;
    logic [7:0]           char_reg;
    logic                 empty_reg;
    logic                 trunc_reg;
    logic                 last_reg;

    logic [NUM_CODES-1:0] eff_mask;
    logic [POS_W-1:0]     eff_pos;
    logic                 eff_matched;
    logic [CODE_W-1:0]    eff_idx;
    logic                 eff_done;
    logic [LEN_W-1:0]     eff_len;
    logic                 eff_ovf;

    match_res_t           mres;
    logic                 acc;
    logic                 out_free;
    logic                 proc_match;
    logic                 proc_value;
    logic                 is_term;
    logic                 wr_en;
    logic                 start_drain;
    logic                 emit_empty;
    logic                 load_drain;
    logic                 drain_last;
    logic                 rd_en;
    logic [7:0]           term;
    logic                 matched_after;
    logic [CODE_W-1:0]    idx_after;
    logic                 done_after;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (st_reg == ST_IDLE) && out_free;
    assign acc      = s_valid && s_ready;

    // a line start clears the line state before the character is looked at
    assign eff_mask    = s_line_start ? ALL_CODES : mask_reg;
    assign eff_pos     = s_line_start ? '0 : pos_reg;
    assign eff_matched = s_line_start ? 1'b0 : matched_reg;
    assign eff_idx     = s_line_start ? '0 : idx_reg;
    assign eff_done    = s_line_start ? 1'b0 : done_reg;
    assign eff_len     = s_line_start ? '0 : len_reg;
    assign eff_ovf     = s_line_start ? 1'b0 : ovf_reg;

    obis_match u_match (
        .mask (eff_mask),
        .pos  (eff_pos),
        .ch   (s_ch),
        .res  (mres)
    );

    assign term        = (eff_idx == TIME_CODE) ? TERM_TIME : TERM_VALUE;
    assign proc_match  = !eff_done && !eff_matched && (eff_mask != '0);
    assign proc_value  = !eff_done && eff_matched;
    assign is_term     = proc_value && (s_ch == term);
    assign wr_en       = acc && proc_value && !is_term && (eff_len < LEN_W'(MAX_VALUE_LEN));
    assign start_drain = is_term && (eff_len != '0);

    assign matched_after = eff_matched || (proc_match && mres.hit);
    assign idx_after     = (proc_match && mres.hit) ? mres.idx : eff_idx;
    assign done_after    = eff_done || is_term;
    assign emit_empty    = (is_term && (eff_len == '0))
                         || (s_line_end && matched_after && !done_after);

    always_comb begin
        mask_next    = eff_mask;
        pos_next     = eff_pos;
        matched_next = matched_after;
        idx_next     = idx_after;
        done_next    = done_after;
        len_next     = eff_len;
        ovf_next     = eff_ovf;
        if (proc_match) begin
            mask_next = mres.mask;
            if (eff_pos != POS_MAX) begin
                pos_next = eff_pos + 1'b1;
            end
        end
        if (proc_value && !is_term) begin
            if (eff_len < LEN_W'(MAX_VALUE_LEN)) begin
                len_next = eff_len + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (s_line_end) begin
            mask_next    = ALL_CODES;
            pos_next     = '0;
            matched_next = 1'b0;
            idx_next     = '0;
            done_next    = 1'b0;
            len_next     = '0;
            ovf_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= ALL_CODES;
            pos_reg     <= '0;
            matched_reg <= 1'b0;
            idx_reg     <= '0;
            done_reg    <= 1'b0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
        end else if (acc) begin
            mask_reg    <= mask_next;
            pos_reg     <= pos_next;
            matched_reg <= matched_next;
            idx_reg     <= idx_next;
            done_reg    <= done_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
        end
    end

    // drain sequencer: read one buffer entry, then move it to the output register
    assign drain_last = (LEN_W'(dr_idx_reg + 1'b1) == dr_len_reg);
    assign load_drain = (st_reg == ST_LOAD) && out_free;
    assign rd_en      = (st_reg == ST_READ);

    always_comb begin
        st_next     = st_reg;
        dr_idx_next = dr_idx_reg;
        case (st_reg)
            ST_IDLE: begin
                if (acc && start_drain) begin
                    st_next     = ST_READ;
                    dr_idx_next = '0;
                end
            end
            ST_READ: begin
                st_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    if (drain_last) begin
                        st_next = ST_IDLE;
                    end else begin
                        st_next     = ST_READ;
                        dr_idx_next = dr_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            dr_idx_reg <= '0;
        end else begin
            st_reg     <= st_next;
            dr_idx_reg <= dr_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && start_drain) begin
            dr_len_reg  <= eff_len;
            dr_code_reg <= eff_idx;
            dr_ovf_reg  <= eff_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_mem[eff_len[ADDR_W-1:0]] <= s_ch;
        end
        if (rd_en) begin
            rd_data_reg <= value_mem[dr_idx_reg[ADDR_W-1:0]];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if ((acc && emit_empty) || load_drain) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && emit_empty) begin
            code_reg  <= idx_after;
            char_reg  <= 8'h00;
            empty_reg <= 1'b1;
            trunc_reg <= 1'b0;
            last_reg  <= 1'b1;
        end else if (load_drain) begin
            code_reg  <= dr_code_reg;
            char_reg  <= rd_data_reg;
            empty_reg <= 1'b0;
            trunc_reg <= dr_ovf_reg;
            last_reg  <= drain_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_code_index    = code_reg;
    assign m_value_char    = char_reg;
    assign m_value_empty   = empty_reg;
    assign m_truncated     = trunc_reg;
    assign m_last_of_value = last_reg;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import obis_pkg::*;

    localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(NUM_CODES - 1);
    localparam logic [7:0]  EOV_TIME  = "W";
    localparam logic [7:0]  EOV_VALUE = "*";
    localparam int unsigned POS_LIMIT = 15;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [7:0]        value_char;
        logic              empty;
        logic              trunc;
        logic              last;
    } value_result_t;

    typedef struct packed {
        logic [7:0]        ch;
        logic              line_start;
        logic              line_end;
        logic              empty_expected;
        logic [CODE_W-1:0] code;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_ch;
    logic              s_line_start;
    logic              s_line_end;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CODE_W-1:0] m_code_index;
    logic [7:0]        m_value_char;
    logic              m_value_empty;
    logic              m_truncated;
    logic              m_last_of_value;

    obis_line_value_extractor_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_line_start    (s_line_start),
        .s_line_end      (s_line_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_index    (m_code_index),
        .m_value_char    (m_value_char),
        .m_value_empty   (m_value_empty),
        .m_truncated     (m_truncated),
        .m_last_of_value (m_last_of_value)
    );

    string obis_prefix [NUM_CODES] = '{
        "0-0:1.0.0(",  "1-0:1.8.0(",  "1-0:2.8.0(",  "1-0:3.8.0(",
        "1-0:4.8.0(",  "1-0:1.7.0(",  "1-0:2.7.0(",  "1-0:3.7.0(",
        "1-0:4.7.0(",  "1-0:21.7.0(", "1-0:41.7.0(", "1-0:61.7.0(",
        "1-0:22.7.0(", "1-0:42.7.0(", "1-0:62.7.0(", "1-0:23.7.0(",
        "1-0:43.7.0(", "1-0:63.7.0(", "1-0:24.7.0(", "1-0:44.7.0(",
        "1-0:64.7.0(", "1-0:32.7.0(", "1-0:52.7.0(", "1-0:72.7.0(",
        "1-0:31.7.0(", "1-0:51.7.0(", "1-0:71.7.0("
    };

    stim_row_t directed_rows [25] = '{
        '{8'h00, 1'b1, 1'b1, 1'b0, 5'd0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 5'd0},
        '{"0",   1'b1, 1'b0, 1'b0, 5'd0},
        '{"-",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"0",   1'b0, 1'b0, 1'b0, 5'd0},
        '{":",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"1",   1'b0, 1'b0, 1'b0, 5'd0},
        '{".",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"0",   1'b0, 1'b0, 1'b0, 5'd0},
        '{".",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"0",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"(",   1'b0, 1'b0, 1'b0, 5'd0},
        // terminator right after the open paren: empty timestamp value
        '{"W",   1'b0, 1'b0, 1'b1, TIME_CODE},
        // ignored after the terminator
        '{"*",   1'b0, 1'b1, 1'b0, 5'd0},
        // no line_start: the previous line end already opened a new line
        '{"1",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"-",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"0",   1'b0, 1'b0, 1'b0, 5'd0},
        '{":",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"7",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"1",   1'b0, 1'b0, 1'b0, 5'd0},
        '{".",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"7",   1'b0, 1'b0, 1'b0, 5'd0},
        '{".",   1'b0, 1'b0, 1'b0, 5'd0},
        '{"0",   1'b0, 1'b0, 1'b0, 5'd0},
        // line ends on the open paren: missing terminator
        '{"(",   1'b0, 1'b1, 1'b1, LAST_CODE}
    };

    // line parser state
    logic [NUM_CODES-1:0] live_codes;
    int unsigned          prefix_pos;
    bit                   code_found;
    logic [CODE_W-1:0]    found_code;
    bit                   value_closed;
    logic [7:0]           value_store [MAX_VALUE_LEN];
    int unsigned          value_count;
    bit                   value_dropped;

    value_result_t step_results [$];
    value_result_t expected_results [$];
    logic [7:0]    line_buf [$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned sink_hold      = 0;
    int unsigned chars_sent     = 0;
    int unsigned mismatch_count = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function void clear_line_state();
        live_codes    = '1;
        prefix_pos    = 0;
        code_found    = 1'b0;
        found_code    = '0;
        value_closed  = 1'b0;
        value_count   = 0;
        value_dropped = 1'b0;
    endfunction

    function void add_value_result(logic [7:0] c, bit empty, bit trunc, bit last);
        value_result_t r;
        r.code       = found_code;
        r.value_char = c;
        r.empty      = empty;
        r.trunc      = trunc;
        r.last       = last;
        step_results.push_back(r);
    endfunction

    // results of one accepted character, left in step_results
    function void parse_char(logic [7:0] c, bit ls, bit le);
        int         i;
        logic [7:0] term;
        step_results.delete();
        if (ls) clear_line_state();
        if (!value_closed) begin
            if (!code_found) begin
                if (live_codes != '0) begin
                    for (i = 0; i < NUM_CODES; i++) begin
                        if (live_codes[i] && (prefix_pos >= obis_prefix[i].len() ||
                                obis_prefix[i][prefix_pos] != c))
                            live_codes[i] = 1'b0;
                    end
                    for (i = 0; i < NUM_CODES && !code_found; i++) begin
                        if (live_codes[i] && obis_prefix[i].len() == prefix_pos + 1) begin
                            code_found = 1'b1;
                            found_code = CODE_W'(i);
                        end
                    end
                    if (prefix_pos < POS_LIMIT) prefix_pos++;
                end
            end else begin
                term = (found_code == TIME_CODE) ? EOV_TIME : EOV_VALUE;
                if (c == term) begin
                    if (value_count == 0) begin
                        add_value_result(8'h00, 1'b1, 1'b0, 1'b1);
                    end else begin
                        for (i = 0; i < value_count; i++)
                            add_value_result(value_store[i], 1'b0, value_dropped,
                                             i + 1 == value_count);
                    end
                    value_closed = 1'b1;
                end else if (value_count < MAX_VALUE_LEN) begin
                    value_store[value_count] = c;
                    value_count++;
                end else begin
                    value_dropped = 1'b1;
                end
            end
        end
        if (le) begin
            if (code_found && !value_closed) add_value_result(8'h00, 1'b1, 1'b0, 1'b1);
            clear_line_state();
        end
    endfunction

    task send_char(input logic [7:0] c, input bit ls, input bit le, input bit hand_typed);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_ch         <= c;
        s_line_start <= ls;
        s_line_end   <= le;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        parse_char(c, ls, le);
        if (!hand_typed) begin
            foreach (step_results[k]) expected_results.push_back(step_results[k]);
        end
    endtask

    task emit_line(input bit open);
        int k;
        for (k = 0; k < line_buf.size(); k++)
            send_char(line_buf[k], open && k == 0, k == line_buf.size() - 1, 1'b0);
    endtask

    task well_formed_line(input int unsigned vlen, input bit with_term);
        int unsigned idx;
        int          k;
        logic [7:0]  term;
        logic [7:0]  c;
        idx  = $urandom_range(NUM_CODES - 1);
        term = (idx == 0) ? EOV_TIME : EOV_VALUE;
        line_buf.delete();
        for (k = 0; k < obis_prefix[idx].len(); k++) line_buf.push_back(obis_prefix[idx][k]);
        repeat (vlen) begin
            c = 8'($urandom_range(255));
            if (c == term) c = c ^ 8'h01;
            line_buf.push_back(c);
        end
        if (with_term) line_buf.push_back(term);
        repeat ($urandom_range(2)) line_buf.push_back(8'($urandom_range(255)));
        emit_line($urandom_range(9) != 0);
    endtask

    task random_traffic(input int unsigned count);
        int unsigned upto;
        int unsigned pick;
        int unsigned roll;
        int unsigned vlen;
        int unsigned idx;
        int unsigned cut;
        int          k;
        logic [7:0]  c;
        upto = chars_sent + count;
        while (chars_sent < upto) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                roll = $urandom_range(99);
                if (roll < 80)      vlen = $urandom_range(6);
                else if (roll < 94) vlen = $urandom_range(31, 7);
                else                vlen = $urandom_range(40, 32);
                well_formed_line(vlen, $urandom_range(99) < 85);
            end else if (pick < 85) begin
                // prefix broken part way through
                idx = $urandom_range(NUM_CODES - 1);
                cut = $urandom_range(obis_prefix[idx].len() - 1, 1);
                line_buf.delete();
                for (k = 0; k < cut; k++) line_buf.push_back(obis_prefix[idx][k]);
                c = 8'($urandom_range(255));
                if (c == obis_prefix[idx][cut]) c = c ^ 8'h01;
                line_buf.push_back(c);
                repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(255)));
                emit_line(1'b1);
            end else begin
                repeat ($urandom_range(6, 1))
                    send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'b0);
            end
        end
    endtask

    task drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction code %0d char %02h",
                                          m_code_index, m_value_char));
            end else begin
                if (m_code_index != expected_results[0].code)
                    report_mismatch($sformatf("code_index got %0d want %0d",
                                              m_code_index, expected_results[0].code));
                if (m_value_char != expected_results[0].value_char)
                    report_mismatch($sformatf("value_char got %02h want %02h",
                                              m_value_char, expected_results[0].value_char));
                if (m_value_empty != expected_results[0].empty)
                    report_mismatch($sformatf("value_empty got %0b want %0b",
                                              m_value_empty, expected_results[0].empty));
                if (m_truncated != expected_results[0].trunc)
                    report_mismatch($sformatf("truncated got %0b want %0b",
                                              m_truncated, expected_results[0].trunc));
                if (m_last_of_value != expected_results[0].last)
                    report_mismatch($sformatf("last_of_value got %0b want %0b",
                                              m_last_of_value, expected_results[0].last));
                void'(expected_results.pop_front());
            end
        end
        if (sink_hold != 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        value_result_t typed_result;
        s_valid      <= 1'b0;
        s_ch         <= 8'h00;
        s_line_start <= 1'b0;
        s_line_end   <= 1'b0;
        aresetn      <= 1'b0;
        clear_line_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            send_char(directed_rows[r].ch, directed_rows[r].line_start,
                      directed_rows[r].line_end, directed_rows[r].empty_expected);
            if (directed_rows[r].empty_expected) begin
                typed_result = '{directed_rows[r].code, 8'h00, 1'b1, 1'b0, 1'b1};
                expected_results.push_back(typed_result);
            end
        end

        // receiver holds off while an overlong value and more lines go in
        sink_hold = 300;
        well_formed_line(36, 1'b1);
        random_traffic(32);
        drain_results();

        src_idle_pct = 52;
        random_traffic(32);
        drain_results();

        src_idle_pct   = 0;
        sink_stall_pct = 52;
        random_traffic(32);
        drain_results();

        src_idle_pct   = 30;
        sink_stall_pct = 30;
        random_traffic(32);
        drain_results();
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
